[design/pste_pkg.sv]
`default_nettype none
package pste_pkg;

  // Buffer limit for one token, in stored bytes.
  localparam int TOKEN_BYTE_LIMIT = 4096;

  // Fixed widths of the channel fields.
  localparam int FIELD_W   = 12;
  localparam int BYTE_W    = 8;
  localparam int TOKENS_W  = 16;
  localparam int DEPTH_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Counters must hold the limit itself; kept indices stay below it.
  localparam int CNT_W  = $clog2(TOKEN_BYTE_LIMIT + 1);
  localparam int KIDX_W = $clog2(TOKEN_BYTE_LIMIT);
  localparam int CMP_W  = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
  localparam int PROD_W = CNT_W + 4;

  localparam logic [DEPTH_W-1:0]  DEPTH_MAX  = '1;
  localparam logic [TOKENS_W-1:0] TOKENS_MAX = '1;

  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_HIGH   = 8'hC0;
  localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;

  localparam logic [FIELD_W-1:0]  RST_MIN_CLEAN  = 12'd4;
  localparam logic [FIELD_W-1:0]  RST_MAX_CLEAN  = 12'd600;
  localparam logic [FIELD_W-1:0]  RST_MIN_TEXT   = 12'd3;
  localparam logic [TOKENS_W-1:0] RST_MAX_TOKENS = 16'd2000;

  typedef enum logic {
    OP_DATA = 1'b0,
    OP_END  = 1'b1
  } op_t;

  typedef enum logic {
    KIND_CHAR    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_CLEAN  = 2'd0,
    CFG_MAX_CLEAN  = 2'd1,
    CFG_MIN_TEXT   = 2'd2,
    CFG_MAX_TOKENS = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  min_clean_bytes;
    logic [FIELD_W-1:0]  max_clean_bytes;
    logic [FIELD_W-1:0]  min_text_chars;
    logic [TOKENS_W-1:0] max_tokens;
  } cfg_t;

  typedef struct packed {
    logic               in_string;
    logic               escape_pending;
    logic               seen_nonblank;
    logic [DEPTH_W-1:0] nest_depth;
    logic [CNT_W-1:0]   raw_count;
    logic [CNT_W-1:0]   printable_count;
    logic [CNT_W-1:0]   kept_count;
    logic [KIDX_W-1:0]  first_nonblank;
    logic [KIDX_W-1:0]  last_nonblank;
  } scan_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  char_value;
    logic [FIELD_W-1:0] char_index;
    logic               kept;
    logic [FIELD_W-1:0] kept_index;
    logic               accepted;
    logic [FIELD_W-1:0] trim_first;
    logic [FIELD_W-1:0] text_len;
  } result_t;

endpackage
`default_nettype wire

[design/pste_if.sv]
`default_nettype none
interface pste_in_if import pste_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [BYTE_W-1:0]   data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface pste_out_if import pste_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [BYTE_W-1:0]   char_value;
  logic [FIELD_W-1:0]  char_index;
  logic                kept;
  logic [FIELD_W-1:0]  kept_index;
  logic                accepted;
  logic [FIELD_W-1:0]  trim_first;
  logic [FIELD_W-1:0]  text_len;

  modport source (output valid, output kind, output char_value, output char_index,
                  output kept, output kept_index, output accepted, output trim_first,
                  output text_len, input ready);
  modport sink   (input valid, input kind, input char_value, input char_index,
                  input kept, input kept_index, input accepted, input trim_first,
                  input text_len, output ready);
endinterface

interface pste_cfg_if import pste_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[design/pste_cfg_regs.sv]
`default_nettype none
module pste_cfg_regs import pste_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pste_cfg_if.sink    cfg_if,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (cfg_reg_t'(cfg_if.index))
        CFG_MIN_CLEAN:  cfg_nxt.min_clean_bytes = cfg_if.data[FIELD_W-1:0];
        CFG_MAX_CLEAN:  cfg_nxt.max_clean_bytes = cfg_if.data[FIELD_W-1:0];
        CFG_MIN_TEXT:   cfg_nxt.min_text_chars  = cfg_if.data[FIELD_W-1:0];
        CFG_MAX_TOKENS: cfg_nxt.max_tokens      = cfg_if.data[TOKENS_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_clean_bytes <= RST_MIN_CLEAN;
      cfg_r.max_clean_bytes <= RST_MAX_CLEAN;
      cfg_r.min_text_chars  <= RST_MIN_TEXT;
      cfg_r.max_tokens      <= RST_MAX_TOKENS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

[design/pste_scanner.sv]
`default_nettype none
module pste_scanner import pste_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire logic              op,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire cfg_t              cfg,
  output logic                   res_valid,
  output result_t                res
);

  scan_t               scan_r;
  scan_t               scan_nxt;
  logic [TOKENS_W-1:0] tokens_r;
  logic [TOKENS_W-1:0] tokens_nxt;

  logic               printable;
  logic               keep;
  logic               nonblank;
  logic               room;
  logic               do_store;
  logic               do_close;
  logic               do_abort;
  logic [CNT_W-1:0]   tl;
  logic [CMP_W-1:0]   raw_cmp;
  logic [PROD_W-1:0]  prt_x10;
  logic [PROD_W-1:0]  raw_x7;
  logic               acc;
  logic [KIDX_W-1:0]  kidx;

  localparam scan_t SCAN_CLEAR = '0;

  always_comb begin
    printable = (data_byte == CH_TAB) || (data_byte == CH_LF) || (data_byte == CH_CR) ||
                ((data_byte >= CH_SPACE) && (data_byte < CH_DEL)) || (data_byte >= CH_HIGH);
    keep      = !((data_byte == CH_CR) || (data_byte < CH_TAB) ||
                  ((data_byte > CH_CR) && (data_byte < CH_SPACE)));
    nonblank  = (data_byte != CH_SPACE) && (data_byte != CH_TAB);
    room      = scan_r.raw_count < CNT_W'(TOKEN_BYTE_LIMIT);
    kidx      = KIDX_W'(scan_r.kept_count);

    // Verdict terms from the state as it stands before this word.
    tl      = scan_r.seen_nonblank ?
              (CNT_W'(scan_r.last_nonblank) - CNT_W'(scan_r.first_nonblank) + CNT_W'(1)) :
              '0;
    raw_cmp = CMP_W'(scan_r.raw_count);
    prt_x10 = PROD_W'(scan_r.printable_count) * PROD_W'(10);
    raw_x7  = PROD_W'(scan_r.raw_count) * PROD_W'(7);
    acc     = (raw_cmp >= CMP_W'(cfg.min_clean_bytes)) &&
              (raw_cmp <= CMP_W'(cfg.max_clean_bytes)) &&
              (prt_x10 >= raw_x7) &&
              (CMP_W'(tl) >= CMP_W'(cfg.min_text_chars));

    scan_nxt   = scan_r;
    tokens_nxt = tokens_r;
    do_store   = 1'b0;
    do_close   = 1'b0;
    do_abort   = 1'b0;

    if (op == OP_END) begin
      scan_nxt   = SCAN_CLEAR;
      tokens_nxt = '0;
    end else if (tokens_r >= cfg.max_tokens) begin
      scan_nxt = scan_r;
    end else if (!scan_r.in_string) begin
      if (data_byte == CH_LPAREN) begin
        scan_nxt            = SCAN_CLEAR;
        scan_nxt.in_string  = 1'b1;
        scan_nxt.nest_depth = DEPTH_W'(1);
      end
    end else if (scan_r.escape_pending) begin
      scan_nxt.escape_pending = 1'b0;
      do_store = room;
    end else if (data_byte == CH_BSLASH) begin
      scan_nxt.escape_pending = 1'b1;
    end else if (data_byte == CH_LPAREN) begin
      if (scan_r.nest_depth != DEPTH_MAX) begin
        scan_nxt.nest_depth = scan_r.nest_depth + DEPTH_W'(1);
      end
      do_store = room;
    end else if (data_byte == CH_RPAREN) begin
      if (scan_r.nest_depth == DEPTH_W'(1)) begin
        do_close = 1'b1;
      end else begin
        scan_nxt.nest_depth = scan_r.nest_depth - DEPTH_W'(1);
        do_store = room;
      end
    end else if (room) begin
      do_store = 1'b1;
    end else begin
      do_abort = 1'b1;
    end

    res_valid = do_store || do_close || do_abort;
    res       = '0;
    res.kind  = KIND_CHAR;

    if (do_store) begin
      scan_nxt.raw_count = scan_r.raw_count + CNT_W'(1);
      if (printable) begin
        scan_nxt.printable_count = scan_r.printable_count + CNT_W'(1);
      end
      if (keep) begin
        scan_nxt.kept_count = scan_r.kept_count + CNT_W'(1);
        if (nonblank) begin
          if (!scan_r.seen_nonblank) begin
            scan_nxt.first_nonblank = kidx;
            scan_nxt.seen_nonblank  = 1'b1;
          end
          scan_nxt.last_nonblank = kidx;
        end
      end
      res.char_value = data_byte;
      res.char_index = FIELD_W'(scan_r.raw_count);
      res.kept       = keep;
      res.kept_index = keep ? FIELD_W'(kidx) : '0;
    end

    if (do_close) begin
      if (acc && (tokens_r != TOKENS_MAX)) begin
        tokens_nxt = tokens_r + TOKENS_W'(1);
      end
      scan_nxt       = SCAN_CLEAR;
      res.kind       = KIND_VERDICT;
      res.accepted   = acc;
      res.trim_first = scan_r.seen_nonblank ? FIELD_W'(scan_r.first_nonblank) : '0;
      res.text_len   = FIELD_W'(tl);
    end

    if (do_abort) begin
      scan_nxt = SCAN_CLEAR;
      res.kind = KIND_VERDICT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r   <= SCAN_CLEAR;
      tokens_r <= '0;
    end else if (fire) begin
      scan_r   <= scan_nxt;
      tokens_r <= tokens_nxt;
    end
  end

endmodule
`default_nettype wire

[design/paren_string_text_extractor.sv]
`default_nettype none
// Scans a document byte stream for parenthesized literal strings and reports every stored
// byte of an open token as a character word, then one verdict word when the outermost
// close paren arrives or the token overruns its 4096-byte buffer. Words enter an input
// register, the scanner state and the result are worked out combinationally, and the result
// lands in an output register, so one byte is taken every clock while the output is not
// stalled. A byte passes through the input register and then the output register before its
// result is valid at the output. A result waiting at the output holds the next byte in the
// input register, and the input then stalls until that result is taken. Bytes that cause
// no result (delimiters, escapes, bytes outside a string) produce no output word.
// Configuration writes are taken at any time and should be made while the block is idle.
module paren_string_text_extractor import pste_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pste_in_if.sink    in_if,
  pste_out_if.source out_if,
  pste_cfg_if.sink   cfg_if
);

  cfg_t              cfg;
  logic              in_valid_r;
  logic              in_valid_nxt;
  logic              in_op_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  result_t           out_res_r;
  logic              fire;
  logic              in_take;
  logic              res_valid;
  result_t           res;

  pste_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  pste_scanner u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .op        (in_op_r),
    .data_byte (in_byte_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // The held word is processed once the output register has room for its result.
  assign fire        = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || fire;
  assign in_take     = in_if.valid && in_if.ready;

  always_comb begin
    in_valid_nxt = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_r);
    if (fire) begin
      out_valid_nxt = res_valid;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_op_r   <= in_if.op;
      in_byte_r <= in_if.data_byte;
    end
    if (fire && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.kind       = out_res_r.kind;
  assign out_if.char_value = out_res_r.char_value;
  assign out_if.char_index = out_res_r.char_index;
  assign out_if.kept       = out_res_r.kept;
  assign out_if.kept_index = out_res_r.kept_index;
  assign out_if.accepted   = out_res_r.accepted;
  assign out_if.trim_first = out_res_r.trim_first;
  assign out_if.text_len   = out_res_r.text_len;

endmodule
`default_nettype wire

[tb/tb_paren_string_text_extractor.sv]
`timescale 1ns / 1ps
module tb_paren_string_text_extractor;
  import pste_pkg::*;

  // Predicts the character and verdict words of the literal string scanner and checks the
  // words that come out of the block against them, oldest first.
  class token_word_scoreboard;
    logic [FIELD_W-1:0]  min_clean;
    logic [FIELD_W-1:0]  max_clean;
    logic [FIELD_W-1:0]  min_text;
    logic [TOKENS_W-1:0] max_tokens;

    bit                  in_str;
    bit                  esc_pending;
    bit                  seen_nb;
    logic [DEPTH_W-1:0]  depth;
    logic [CNT_W-1:0]    raw_cnt;
    logic [CNT_W-1:0]    print_cnt;
    logic [CNT_W-1:0]    kept_cnt;
    logic [CNT_W-1:0]    first_nb;
    logic [CNT_W-1:0]    last_nb;
    logic [TOKENS_W-1:0] accept_cnt;

    result_t             expected_words[$];
    int                  failures;

    function new();
      min_clean  = RST_MIN_CLEAN;
      max_clean  = RST_MAX_CLEAN;
      min_text   = RST_MIN_TEXT;
      max_tokens = RST_MAX_TOKENS;
      accept_cnt = '0;
      failures   = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      in_str      = 1'b0;
      esc_pending = 1'b0;
      seen_nb     = 1'b0;
      depth       = '0;
      raw_cnt     = '0;
      print_cnt   = '0;
      kept_cnt    = '0;
      first_nb    = '0;
      last_nb     = '0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_DAT_W-1:0] v);
      case (r)
        CFG_MIN_CLEAN:  min_clean  = v[FIELD_W-1:0];
        CFG_MAX_CLEAN:  max_clean  = v[FIELD_W-1:0];
        CFG_MIN_TEXT:   min_text   = v[FIELD_W-1:0];
        CFG_MAX_TOKENS: max_tokens = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void add_expected(result_t w);
      expected_words.insert(expected_words.size(), w);
    endfunction

    function void push_stored(logic [BYTE_W-1:0] c);
      bit      printable;
      bit      keep;
      result_t w;
      printable = c == CH_TAB || c == CH_LF || c == CH_CR ||
                  (c >= CH_SPACE && c < CH_DEL) || c >= CH_HIGH;
      keep = !(c == CH_CR || c < CH_TAB || (c > CH_CR && c < CH_SPACE));
      w = '0;
      w.kind       = KIND_CHAR;
      w.char_value = c;
      w.char_index = raw_cnt[FIELD_W-1:0];
      w.kept       = keep;
      raw_cnt++;
      if (printable) print_cnt++;
      if (keep) begin
        w.kept_index = kept_cnt[FIELD_W-1:0];
        if (c != CH_SPACE && c != CH_TAB) begin
          if (!seen_nb) begin
            first_nb = kept_cnt;
            seen_nb  = 1'b1;
          end
          last_nb = kept_cnt;
        end
        kept_cnt++;
      end
      add_expected(w);
    endfunction

    function void push_verdict(bit acc, logic [FIELD_W-1:0] tf, logic [FIELD_W-1:0] tl);
      result_t w;
      w = '0;
      w.kind       = KIND_VERDICT;
      w.accepted   = acc;
      w.trim_first = tf;
      w.text_len   = tl;
      clear_scan();
      add_expected(w);
    endfunction

    // Works out the words caused by one accepted input word.
    function void take_item(op_t op, logic [BYTE_W-1:0] c);
      int unsigned tl;
      bit          room;
      bit          acc;
      if (op == OP_END) begin
        clear_scan();
        accept_cnt = '0;
        return;
      end
      if (accept_cnt >= max_tokens) return;
      if (!in_str) begin
        if (c == CH_LPAREN) begin
          clear_scan();
          in_str = 1'b1;
          depth  = DEPTH_W'(1);
        end
        return;
      end
      room = raw_cnt < TOKEN_BYTE_LIMIT;
      if (esc_pending) begin
        esc_pending = 1'b0;
        if (room) push_stored(c);
        return;
      end
      if (c == CH_BSLASH) begin
        esc_pending = 1'b1;
        return;
      end
      if (c == CH_LPAREN) begin
        if (depth != DEPTH_MAX) depth++;
        if (room) push_stored(c);
        return;
      end
      if (c == CH_RPAREN) begin
        depth--;
        if (depth == 0) begin
          tl  = seen_nb ? last_nb - first_nb + 1 : 0;
          acc = raw_cnt >= min_clean && raw_cnt <= max_clean &&
                print_cnt * 10 >= raw_cnt * 7 && tl >= min_text;
          if (acc && accept_cnt != TOKENS_MAX) accept_cnt++;
          push_verdict(acc, seen_nb ? first_nb[FIELD_W-1:0] : '0, FIELD_W'(tl));
          return;
        end
        if (room) push_stored(c);
        return;
      end
      // An ordinary byte with no room left aborts the token.
      if (room) push_stored(c);
      else push_verdict(1'b0, '0, '0);
    endfunction

    function string show(result_t w);
      return $sformatf("kind=%0d char=%h idx=%0d kept=%0d kidx=%0d acc=%0d trim=%0d len=%0d",
                       w.kind, w.char_value, w.char_index, w.kept, w.kept_index,
                       w.accepted, w.trim_first, w.text_len);
    endfunction

    function void check_word(result_t got);
      result_t want;
      bit      bad;
      if (expected_words.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected word: %s", show(got));
        return;
      end
      want = expected_words.pop_front();
      bad = got.kind !== want.kind || got.char_value !== want.char_value ||
            got.char_index !== want.char_index || got.kept !== want.kept ||
            got.kept_index !== want.kept_index || got.accepted !== want.accepted ||
            got.trim_first !== want.trim_first || got.text_len !== want.text_len;
      if (bad) begin
        failures++;
        if (failures <= 10) begin
          $display("word mismatch at %0t", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction

    function void count_leftovers();
      if (expected_words.size() > 0) begin
        if (failures < 10)
          $display("%0d expected words never arrived", expected_words.size());
        failures += expected_words.size();
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on = 1'b1;
  bit   hold_toggle = 1'b0;
  int   token_bytes = 0;

  token_word_scoreboard sb;

  pste_in_if  in_ch();
  pste_out_if out_ch();
  pste_cfg_if cfg_ch();

  paren_string_text_extractor i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stalls while idle_on is set, plus a long hold-off whenever the stimulus asks for one.
  initial begin
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (!idle_on) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= 20);
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.kind       = kind_t'(out_ch.kind);
      got.char_value = out_ch.char_value;
      got.char_index = out_ch.char_index;
      got.kept       = out_ch.kept;
      got.kept_index = out_ch.kept_index;
      got.accepted   = out_ch.accepted;
      got.trim_first = out_ch.trim_first;
      got.text_len   = out_ch.text_len;
      sb.check_word(got);
    end
  end

  task automatic send_word(op_t op, logic [BYTE_W-1:0] b);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 20) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.op        = op;
    in_ch.data_byte = b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.take_item(op, b);
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_word(OP_DATA, s[i]);
  endtask

  // Lowers the input valid and waits until every expected word is out, then lets the
  // pipeline settle in case the last bytes caused no word.
  task automatic wait_drained();
    int n;
    n = 0;
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() > 0 && n < 40000) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DAT_W-1:0] v);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = r;
    cfg_ch.data  = v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.set_reg(r, v);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic write_all(int mn, int mx, int txt, int tokens);
    write_reg(CFG_MIN_CLEAN, CFG_DAT_W'(mn));
    write_reg(CFG_MAX_CLEAN, CFG_DAT_W'(mx));
    write_reg(CFG_MIN_TEXT, CFG_DAT_W'(txt));
    write_reg(CFG_MAX_TOKENS, CFG_DAT_W'(tokens));
  endtask

  function automatic logic [BYTE_W-1:0] pick_text_byte();
    logic [BYTE_W-1:0] b;
    if ($urandom_range(0, 9) == 0) begin
      b = BYTE_W'($urandom_range(8'hC0, 8'hFF));
    end else begin
      b = BYTE_W'($urandom_range(8'h21, 8'h7E));
      if (b == CH_LPAREN || b == CH_RPAREN || b == CH_BSLASH) b = 8'h61;
    end
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_control_byte();
    logic [BYTE_W-1:0] b;
    case ($urandom_range(0, 3))
      0: b = BYTE_W'($urandom_range(0, 8));
      1: b = BYTE_W'($urandom_range(11, 31));
      2: b = BYTE_W'($urandom_range(8'h7F, 8'hBF));
      default: b = CH_CR;
    endcase
    return b;
  endfunction

  function automatic int pick_len();
    int r;
    int lo;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 12);
    if (r < 80 && sb.min_clean <= 700) begin
      lo = int'(sb.min_clean) - 2;
      return (lo < 0 ? 0 : lo) + $urandom_range(0, 4);
    end
    if (r < 90 && sb.max_clean <= 700) begin
      lo = int'(sb.max_clean) - 2;
      return (lo < 0 ? 0 : lo) + $urandom_range(0, 4);
    end
    return $urandom_range(13, 60);
  endfunction

  // One literal string with random content: escapes, nested parens, blanks and a variable
  // share of control bytes. A few are cut off by an end word or left open.
  task automatic send_token(int body_len);
    int i;
    int r;
    int open_inner;
    int noise;
    open_inner = 0;
    noise = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    send_word(OP_DATA, CH_LPAREN);
    for (i = 0; i < body_len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_word(OP_DATA, CH_BSLASH);
        send_word(OP_DATA, BYTE_W'($urandom_range(0, 255)));
      end else if (r < 10) begin
        send_word(OP_DATA, CH_LPAREN);
        open_inner++;
      end else if (r < 14 && open_inner > 0) begin
        send_word(OP_DATA, CH_RPAREN);
        open_inner--;
      end else if (r < 14 + noise) begin
        send_word(OP_DATA, pick_control_byte());
      end else if (r < 24 + noise) begin
        case ($urandom_range(0, 2))
          0: send_word(OP_DATA, CH_TAB);
          1: send_word(OP_DATA, CH_LF);
          default: send_word(OP_DATA, CH_SPACE);
        endcase
      end else begin
        send_word(OP_DATA, pick_text_byte());
      end
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      send_word(OP_END, BYTE_W'($urandom_range(0, 255)));
    end else if (r >= 8) begin
      repeat (open_inner + 1) send_word(OP_DATA, CH_RPAREN);
    end
    token_bytes += body_len;
  endtask

  task automatic run_tokens(int target);
    int start;
    int tokens;
    logic [BYTE_W-1:0] b;
    start  = token_bytes;
    tokens = 0;
    while (token_bytes - start < target) begin
      if ($urandom_range(0, 99) < 30) begin
        repeat ($urandom_range(1, 3)) begin
          b = BYTE_W'($urandom_range(0, 255));
          if (b == CH_LPAREN) b = CH_RPAREN;
          send_word(OP_DATA, b);
        end
      end
      if ($urandom_range(0, 99) < 2) send_word(OP_END, BYTE_W'($urandom_range(0, 255)));
      send_token(pick_len());
      tokens++;
      if (tokens % 40 == 0) wait_drained();
    end
  endtask

  initial begin
    sb = new();
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_DATA;
    in_ch.data_byte = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_MIN_CLEAN;
    cfg_ch.data     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Bytes outside a string are ignored.
    send_word(OP_DATA, 8'h00);
    send_word(OP_DATA, 8'hFF);
    send_word(OP_DATA, CH_RPAREN);
    send_text("()");
    // Escaped close, nested pair, tab, CR, control, DEL and high bytes in one token.
    send_text("( A\\)b(c)\t");
    send_word(OP_DATA, CH_CR);
    send_word(OP_DATA, 8'h01);
    send_word(OP_DATA, 8'hFF);
    send_word(OP_DATA, CH_DEL);
    send_word(OP_DATA, CH_HIGH);
    send_word(OP_DATA, 8'hBF);
    send_word(OP_DATA, CH_RPAREN);
    send_text("(ab");
    send_word(OP_END, 8'h00);
    wait_drained();

    run_tokens(350);
    wait_drained();

    write_all(0, 4095, 0, 65535);
    run_tokens(220);
    wait_drained();

    // Limits that cannot all be met, so nothing is accepted.
    write_all(4095, 0, 4095, 1);
    run_tokens(110);
    wait_drained();

    // Two acceptances silence the block until an end word.
    write_all(2, 30, 2, 2);
    hold_toggle = ~hold_toggle;
    send_token(100);
    run_tokens(280);
    wait_drained();

    write_all($urandom_range(0, 8), $urandom_range(8, 60), $urandom_range(0, 6),
              $urandom_range(1, 5));
    idle_on = 1'b0;
    run_tokens(120);
    idle_on = 1'b1;
    run_tokens(150);

    wait_drained();
    sb.count_leftovers();
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
